@@ rtl/ilie_pkg.sv @@
package ilie_pkg;

  localparam int OpW    = 4;
  localparam int PosW   = 6;
  localparam int ValueW = 32;
  localparam int CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_PUSH   = 4'd0,
    OP_POP    = 4'd1,
    OP_INSERT = 4'd2,
    OP_ERASE  = 4'd3,
    OP_READ   = 4'd4,
    OP_WRITE  = 4'd5,
    OP_CLEAR  = 4'd6,
    OP_RESIZE = 4'd7,
    OP_ASSIGN = 4'd8,
    OP_FRONT  = 4'd9,
    OP_BACK   = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

endpackage

@@ rtl/ilie_ram.sv @@
module ilie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/indexed_list_insert_erase.sv @@
// Bounded ordered list of CAPACITY signed 32-bit words held in one element RAM
// (one write port, one registered read port) plus an element count. One request
// is handled at a time; the result sits in an output register, and a new request
// is taken while an earlier result still waits there. Push, pop, write, clear,
// range/full/empty errors, insert at the count, erase of the last entry and
// resize/assign that fill nothing finish in S_IDLE. Read, front and back wait in
// S_RDATA for the registered RAM read. The RAM moves one word per cycle, so insert
// below the count runs S_SHIFT_UP, S_PUT, S_EMIT; erase below the last entry runs
// S_SHIFT_DN, S_EMIT; resize/assign that fill entries run S_FILL, S_EMIT. A result
// not taken holds the FSM in S_RDATA or S_EMIT. count_now carries the low 7 bits
// of the count. The element RAM is not cleared at reset; entries are only read once written.
module indexed_list_insert_erase #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ilie_pkg::OpW-1:0]          operation_i,
  input  logic [ilie_pkg::PosW-1:0]         position_i,
  input  logic signed [ilie_pkg::ValueW-1:0] item_value_i,
  input  logic [ilie_pkg::CountW-1:0]       new_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ilie_pkg::ValueW-1:0] read_data_o,
  output logic [ilie_pkg::CountW-1:0]       count_now_o,
  output logic                              is_empty_o,
  output logic [1:0]                        status_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > ilie_pkg::CountW) ? CW : ilie_pkg::CountW;
  localparam logic [XW-1:0] CapX = XW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SHIFT_UP = 7'b0000010,
    S_PUT      = 7'b0000100,
    S_SHIFT_DN = 7'b0001000,
    S_FILL     = 7'b0010000,
    S_RDATA    = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [AW-1:0]             wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]             rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [CW-1:0]             fill_end_q, fill_end_d;
  logic [ilie_pkg::ValueW-1:0] word_q, word_d;
  ilie_pkg::status_e         pend_q, pend_d;

  logic                      out_valid_q, out_valid_d;
  logic [ilie_pkg::ValueW-1:0] read_data_q;
  logic [ilie_pkg::CountW-1:0] count_now_q;
  logic                      is_empty_q;
  ilie_pkg::status_e         status_q;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [ilie_pkg::ValueW-1:0] ram_wdata, ram_rdata;

  logic                      out_free, acc_done, fin;
  logic [XW-1:0]             n_x, pos_x, tgt_x, fin_cnt_x;
  logic [CW-1:0]             fin_cnt;
  logic [ilie_pkg::ValueW-1:0] fin_rd;
  ilie_pkg::status_e         acc_status, fin_status;

  ilie_ram #(
    .WIDTH(ilie_pkg::ValueW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign n_x        = XW'(cnt_q);
  assign pos_x      = XW'(position_i);
  assign tgt_x      = XW'(new_count_i);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    pos_d      = pos_q;
    fill_end_d = fill_end_q;
    word_d     = word_q;
    pend_d     = pend_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_ptr_q;
    ram_wdata  = word_q;
    ram_raddr  = rd_ptr_q;
    acc_status = ilie_pkg::STAT_OK;
    acc_done   = 1'b0;
    fin        = 1'b0;
    fin_rd     = '0;
    fin_cnt    = cnt_q;
    fin_status = ilie_pkg::STAT_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          word_d   = item_value_i;
          acc_done = 1'b1;
          case (operation_i)
            ilie_pkg::OP_PUSH: begin
              if (n_x >= CapX) begin
                acc_status = ilie_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_q);
                ram_wdata = item_value_i;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            ilie_pkg::OP_POP: begin
              if (cnt_q == '0) begin
                acc_status = ilie_pkg::STAT_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            ilie_pkg::OP_INSERT: begin
              if (n_x >= CapX) begin
                acc_status = ilie_pkg::STAT_FULL;
              end else if (pos_x > n_x) begin
                acc_status = ilie_pkg::STAT_RANGE;
              end else begin
                cnt_d = cnt_q + CW'(1);
                if (pos_x == n_x) begin
                  ram_we    = 1'b1;
                  ram_waddr = AW'(pos_x);
                  ram_wdata = item_value_i;
                end else begin
                  // move entries up from the top down to pos, then drop the word in
                  acc_done  = 1'b0;
                  pos_d     = AW'(pos_x);
                  ram_raddr = AW'(cnt_q - CW'(1));
                  wr_ptr_d  = AW'(cnt_q);
                  state_d   = S_SHIFT_UP;
                end
              end
            end
            ilie_pkg::OP_ERASE: begin
              if (pos_x >= n_x) begin
                acc_status = ilie_pkg::STAT_RANGE;
              end else begin
                cnt_d = cnt_q - CW'(1);
                if (pos_x + XW'(1) != n_x) begin
                  acc_done  = 1'b0;
                  ram_raddr = AW'(pos_x + XW'(1));
                  wr_ptr_d  = AW'(pos_x);
                  state_d   = S_SHIFT_DN;
                end
              end
            end
            ilie_pkg::OP_READ: begin
              if (pos_x >= n_x) begin
                acc_status = ilie_pkg::STAT_RANGE;
              end else begin
                acc_done  = 1'b0;
                rd_ptr_d  = AW'(pos_x);
                ram_raddr = AW'(pos_x);
                state_d   = S_RDATA;
              end
            end
            ilie_pkg::OP_WRITE: begin
              if (pos_x >= n_x) begin
                acc_status = ilie_pkg::STAT_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(pos_x);
                ram_wdata = item_value_i;
              end
            end
            ilie_pkg::OP_CLEAR: begin
              cnt_d = '0;
            end
            ilie_pkg::OP_RESIZE: begin
              if (tgt_x > CapX) begin
                acc_status = ilie_pkg::STAT_FULL;
              end else begin
                cnt_d = CW'(tgt_x);
                if (tgt_x > n_x) begin
                  acc_done   = 1'b0;
                  wr_ptr_d   = AW'(cnt_q);
                  fill_end_d = CW'(tgt_x);
                  state_d    = S_FILL;
                end
              end
            end
            ilie_pkg::OP_ASSIGN: begin
              if (tgt_x > CapX) begin
                acc_status = ilie_pkg::STAT_FULL;
              end else begin
                cnt_d = CW'(tgt_x);
                if (tgt_x != '0) begin
                  acc_done   = 1'b0;
                  wr_ptr_d   = '0;
                  fill_end_d = CW'(tgt_x);
                  state_d    = S_FILL;
                end
              end
            end
            ilie_pkg::OP_FRONT: begin
              if (cnt_q == '0) begin
                acc_status = ilie_pkg::STAT_EMPTY;
              end else begin
                acc_done  = 1'b0;
                rd_ptr_d  = '0;
                ram_raddr = '0;
                state_d   = S_RDATA;
              end
            end
            ilie_pkg::OP_BACK: begin
              if (cnt_q == '0) begin
                acc_status = ilie_pkg::STAT_EMPTY;
              end else begin
                acc_done  = 1'b0;
                rd_ptr_d  = AW'(cnt_q - CW'(1));
                ram_raddr = AW'(cnt_q - CW'(1));
                state_d   = S_RDATA;
              end
            end
            default: begin
            end
          endcase
          if (acc_done) begin
            if (out_free) begin
              fin        = 1'b1;
              fin_cnt    = cnt_d;
              fin_status = acc_status;
            end else begin
              pend_d  = acc_status;
              state_d = S_EMIT;
            end
          end
        end
      end
      S_SHIFT_UP: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_q;
        ram_wdata = ram_rdata;
        ram_raddr = wr_ptr_q - AW'(2);
        if (wr_ptr_q == pos_q + AW'(1)) begin
          state_d = S_PUT;
        end else begin
          wr_ptr_d = wr_ptr_q - AW'(1);
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = word_q;
        pend_d    = ilie_pkg::STAT_OK;
        state_d   = S_EMIT;
      end
      S_SHIFT_DN: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_q;
        ram_wdata = ram_rdata;
        ram_raddr = wr_ptr_q + AW'(2);
        // cnt_q already holds the reduced count: last target is cnt_q - 1
        if (CW'(wr_ptr_q) + CW'(1) == cnt_q) begin
          pend_d  = ilie_pkg::STAT_OK;
          state_d = S_EMIT;
        end else begin
          wr_ptr_d = wr_ptr_q + AW'(1);
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_q;
        ram_wdata = word_q;
        if (CW'(wr_ptr_q) + CW'(1) == fill_end_q) begin
          pend_d  = ilie_pkg::STAT_OK;
          state_d = S_EMIT;
        end else begin
          wr_ptr_d = wr_ptr_q + AW'(1);
        end
      end
      S_RDATA: begin
        // address held, so the registered read data stays valid while stalled
        ram_raddr = rd_ptr_q;
        if (out_free) begin
          fin     = 1'b1;
          fin_rd  = ram_rdata;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          fin        = 1'b1;
          fin_status = pend_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign fin_cnt_x   = XW'(fin_cnt);
  assign out_valid_d = fin ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_ptr_q   <= wr_ptr_d;
    rd_ptr_q   <= rd_ptr_d;
    pos_q      <= pos_d;
    fill_end_q <= fill_end_d;
    word_q     <= word_d;
    pend_q     <= pend_d;
    if (fin) begin
      read_data_q <= fin_rd;
      count_now_q <= fin_cnt_x[ilie_pkg::CountW-1:0];
      is_empty_q  <= (fin_cnt == '0);
      status_q    <= fin_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign count_now_o = count_now_q;
  assign is_empty_o  = is_empty_q;
  assign status_o    = status_q;

endmodule

@@ rtl/ilie_checker.sv @@
module ilie_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [ilie_pkg::ValueW-1:0] read_data_o,
  input logic [ilie_pkg::CountW-1:0]        count_now_o,
  input logic                               is_empty_o,
  input logic [1:0]                         status_o
);

  // a result that is not taken holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(count_now_o) && $stable(is_empty_o) && $stable(status_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> count_now_o == '0)
    else $error("empty flag with nonzero count");

  // failed requests never return data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ilie_pkg::STAT_OK |-> read_data_o == '0)
    else $error("data returned on failed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ilie_pkg::STAT_EMPTY |-> is_empty_o)
    else $error("empty status on nonempty list");

endmodule

bind indexed_list_insert_erase ilie_checker u_ilie_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .read_data_o(read_data_o),
  .count_now_o(count_now_o),
  .is_empty_o (is_empty_o),
  .status_o   (status_o)
);

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OpW        = ilie_pkg::OpW;
  localparam int PosW       = ilie_pkg::PosW;
  localparam int ValueW     = ilie_pkg::ValueW;
  localparam int CountW     = ilie_pkg::CountW;
  localparam int ListCap    = 64;
  localparam int WatchLimit = 3000;
  localparam int TailCycles = 100;
  localparam int PrintLimit = 40;

  typedef struct packed {
    logic signed [ValueW-1:0] rd;
    logic [CountW-1:0]        cnt;
    logic                     empty;
    ilie_pkg::status_e        st;
  } list_result_t;

  logic                     clk_i;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic [OpW-1:0]           operation_i   = '0;
  logic [PosW-1:0]          position_i    = '0;
  logic signed [ValueW-1:0] item_value_i  = '0;
  logic [CountW-1:0]        new_count_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic signed [ValueW-1:0] read_data_o;
  logic [CountW-1:0]        count_now_o;
  logic                     is_empty_o;
  logic [1:0]               status_o;

  // shadow copy of the list contents
  logic [ValueW-1:0] model_words [ListCap];
  int                model_len;

  list_result_t pending_results [$];
  list_result_t head_result;
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;
  bit           idle_en        = 1'b1;

  indexed_list_insert_erase #(
    .CAPACITY(ListCap)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .position_i  (position_i),
    .item_value_i(item_value_i),
    .new_count_i (new_count_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .count_now_o (count_now_o),
    .is_empty_o  (is_empty_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic list_result_t apply_list_op(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                                                 logic [ValueW-1:0] val,
                                                 logic [CountW-1:0] tgt);
    list_result_t r;
    int n;
    int i;
    r.rd = '0;
    r.st = ilie_pkg::STAT_OK;
    n = model_len;
    case (op)
      ilie_pkg::OP_PUSH: begin
        if (n >= ListCap) begin
          r.st = ilie_pkg::STAT_FULL;
        end else begin
          model_words[n] = val;
          model_len = n + 1;
        end
      end
      ilie_pkg::OP_POP: begin
        if (n == 0) r.st = ilie_pkg::STAT_EMPTY;
        else model_len = n - 1;
      end
      ilie_pkg::OP_INSERT: begin
        // full is checked ahead of the position
        if (n >= ListCap) begin
          r.st = ilie_pkg::STAT_FULL;
        end else if (int'(pos) > n) begin
          r.st = ilie_pkg::STAT_RANGE;
        end else begin
          for (i = n; i > int'(pos); i--) model_words[i] = model_words[i-1];
          model_words[pos] = val;
          model_len = n + 1;
        end
      end
      ilie_pkg::OP_ERASE: begin
        if (int'(pos) >= n) begin
          r.st = ilie_pkg::STAT_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < n; i++) model_words[i] = model_words[i+1];
          model_len = n - 1;
        end
      end
      ilie_pkg::OP_READ: begin
        if (int'(pos) >= n) r.st = ilie_pkg::STAT_RANGE;
        else r.rd = model_words[pos];
      end
      ilie_pkg::OP_WRITE: begin
        if (int'(pos) >= n) r.st = ilie_pkg::STAT_RANGE;
        else model_words[pos] = val;
      end
      ilie_pkg::OP_CLEAR: model_len = 0;
      ilie_pkg::OP_RESIZE: begin
        if (int'(tgt) > ListCap) begin
          r.st = ilie_pkg::STAT_FULL;
        end else begin
          for (i = n; i < int'(tgt); i++) model_words[i] = val;
          model_len = int'(tgt);
        end
      end
      ilie_pkg::OP_ASSIGN: begin
        if (int'(tgt) > ListCap) begin
          r.st = ilie_pkg::STAT_FULL;
        end else begin
          for (i = 0; i < int'(tgt); i++) model_words[i] = val;
          model_len = int'(tgt);
        end
      end
      ilie_pkg::OP_FRONT: begin
        if (n == 0) r.st = ilie_pkg::STAT_EMPTY;
        else r.rd = model_words[0];
      end
      ilie_pkg::OP_BACK: begin
        if (n == 0) r.st = ilie_pkg::STAT_EMPTY;
        else r.rd = model_words[n-1];
      end
      default: ;  // unused codes leave everything alone
    endcase
    r.cnt   = model_len[CountW-1:0];
    r.empty = (model_len == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ValueW-1:0] want, logic [ValueW-1:0] got);
    if (mismatch_count < PrintLimit) begin
      $display("%0t: %s mismatch, expected %h got %h", $realtime, what, want, got);
    end
    mismatch_count++;
  endtask

  // valid stays high after acceptance; a gap in the next call or a drain lowers it
  task automatic send_request(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                              logic [ValueW-1:0] val, logic [CountW-1:0] tgt);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    position_i   <= pos;
    item_value_i <= val;
    new_count_i  <= tgt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.insert(pending_results.size(), apply_list_op(op, pos, val, tgt));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic send_random_request();
    logic [OpW-1:0]    op;
    logic [PosW-1:0]   pos;
    logic [ValueW-1:0] val;
    logic [CountW-1:0] tgt;
    int sel;
    int hi;
    sel = $urandom_range(0, 99);
    if (sel < 18)      op = ilie_pkg::OP_PUSH;
    else if (sel < 26) op = ilie_pkg::OP_POP;
    else if (sel < 38) op = ilie_pkg::OP_INSERT;
    else if (sel < 48) op = ilie_pkg::OP_ERASE;
    else if (sel < 60) op = ilie_pkg::OP_READ;
    else if (sel < 70) op = ilie_pkg::OP_WRITE;
    else if (sel < 72) op = ilie_pkg::OP_CLEAR;
    else if (sel < 78) op = ilie_pkg::OP_RESIZE;
    else if (sel < 82) op = ilie_pkg::OP_ASSIGN;
    else if (sel < 89) op = ilie_pkg::OP_FRONT;
    else if (sel < 96) op = ilie_pkg::OP_BACK;
    else               op = OpW'($urandom_range(11, 15));
    hi = (model_len > 63) ? 63 : model_len;
    // mostly positions inside the list, sometimes anywhere
    if ($urandom_range(0, 7) == 0) pos = PosW'($urandom_range(0, 63));
    else pos = PosW'($urandom_range(0, hi));
    case ($urandom_range(0, 7))
      0:       val = 32'h7FFF_FFFF;
      1:       val = 32'h8000_0000;
      default: val = $urandom;
    endcase
    if ($urandom_range(0, 9) == 0) tgt = CountW'($urandom_range(0, 127));
    else tgt = CountW'($urandom_range(0, (model_len + 6 > ListCap) ? ListCap : model_len + 6));
    send_request(op, pos, val, tgt);
  endtask

  task automatic test_directed();
    send_request(ilie_pkg::OP_BACK,   0,  32'h1, 0);
    send_request(ilie_pkg::OP_POP,    0,  32'h0, 0);
    send_request(ilie_pkg::OP_FRONT,  0,  32'h0, 0);
    send_request(ilie_pkg::OP_READ,   0,  32'h0, 0);
    send_request(ilie_pkg::OP_ERASE,  0,  32'h0, 0);
    send_request(ilie_pkg::OP_WRITE,  0,  32'hDEAD_BEEF, 0);
    send_request(ilie_pkg::OP_PUSH,   0,  32'h7FFF_FFFF, 0);
    send_request(ilie_pkg::OP_PUSH,   63, 32'h8000_0000, 127);
    send_request(ilie_pkg::OP_INSERT, 0,  32'h1234_5678, 0);
    send_request(ilie_pkg::OP_INSERT, 3,  32'hFFFF_FFFF, 0);  // position equal to count appends
    send_request(ilie_pkg::OP_INSERT, 63, 32'h0, 0);
    send_request(ilie_pkg::OP_WRITE,  1,  32'hA5A5_A5A5, 0);
    send_request(ilie_pkg::OP_READ,   1,  32'h0, 0);
    send_request(ilie_pkg::OP_ERASE,  1,  32'h0, 0);
    send_request(ilie_pkg::OP_FRONT,  0,  32'h0, 0);
    send_request(ilie_pkg::OP_BACK,   0,  32'h0, 0);
    send_request(ilie_pkg::OP_RESIZE, 0,  32'hFFFF_FFFF, 64);
    send_request(ilie_pkg::OP_PUSH,   0,  32'h1, 0);
    send_request(ilie_pkg::OP_INSERT, 0,  32'h2, 0);
    send_request(ilie_pkg::OP_READ,   63, 32'h0, 0);
    send_request(ilie_pkg::OP_RESIZE, 0,  32'h3, 127);
    send_request(ilie_pkg::OP_ASSIGN, 0,  32'h5A5A_5A5A, 5);
    send_request(ilie_pkg::OP_RESIZE, 0,  32'h0, 3);
    send_request(ilie_pkg::OP_CLEAR,  0,  32'h0, 0);
    send_request(4'd15,               42, 32'hFFFF_FFFF, 127);
  endtask

  task automatic test_fill_and_drain();
    int k;
    send_request(ilie_pkg::OP_CLEAR, 0, 32'h0, 0);
    for (k = 0; k < ListCap - 1; k++) send_request(ilie_pkg::OP_PUSH, 0, $urandom, 0);
    send_request(ilie_pkg::OP_INSERT, 0, $urandom, 0);  // longest shift up
    send_request(ilie_pkg::OP_PUSH, 0, $urandom, 0);
    send_request(ilie_pkg::OP_INSERT, 5, $urandom, 0);
    send_request(ilie_pkg::OP_ASSIGN, 0, $urandom, 65);
    send_request(ilie_pkg::OP_ERASE, 0, 32'h0, 0);      // longest shift down
    send_request(ilie_pkg::OP_READ, 62, 32'h0, 0);
    send_request(ilie_pkg::OP_BACK, 0, 32'h0, 0);
    while (model_len > 0) send_request(ilie_pkg::OP_POP, 0, 32'h0, 0);
    send_request(ilie_pkg::OP_POP, 0, 32'h0, 0);
  endtask

  task automatic test_mixed_random(int n_items);
    int k;
    idle_en = 1'b1;
    for (k = 0; k < n_items; k++) begin
      send_random_request();
      if (k == n_items / 2) wait_drained();
    end
  endtask

  task automatic test_back_to_back(int n_items);
    int k;
    idle_en = 1'b0;
    for (k = 0; k < n_items; k++) send_random_request();
    idle_en = 1'b1;
  endtask

  initial begin : sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = idle_en ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, count", '0, count_now_o);
      end else begin
        head_result = pending_results.pop_front();
        if (read_data_o !== head_result.rd) begin
          report_mismatch("read_data", head_result.rd, read_data_o);
        end
        if (count_now_o !== head_result.cnt) begin
          report_mismatch("count_now", head_result.cnt, count_now_o);
        end
        if (is_empty_o !== head_result.empty) begin
          report_mismatch("is_empty", head_result.empty, is_empty_o);
        end
        if (status_o !== head_result.st) begin
          report_mismatch("status", head_result.st, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("[indexed_list_insert_erase] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    model_len = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_drain();
    test_mixed_random(700);
    test_back_to_back(400);
    wait_drained();
    test_mixed_random(290);
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[indexed_list_insert_erase] OK");
    end else begin
      $display("[indexed_list_insert_erase] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ilie_pkg.sv
rtl/ilie_ram.sv
rtl/indexed_list_insert_erase.sv
rtl/ilie_checker.sv
sim/tb_top.sv
